// File: design/line_rasterizer_assert.svh
// assertion macros shared by the line rasterizer checkers
// both macros sample on clk_i and are quiet while rst_ni is low
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_rasterizer check failed");

// consequent checked in the cycle after the antecedent
`define LR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_rasterizer check failed");

`endif

// File: design/lr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg
// shared constants, codes and sizing helpers for the line rasterizer
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int COLOUR_BITS        = 24;

  // word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // signed y step per move
  localparam logic signed [1:0] Y_STEP_NONE = 2'sb00;
  localparam logic signed [1:0] Y_STEP_UP   = 2'sb01;
  localparam logic signed [1:0] Y_STEP_DOWN = 2'sb11;

  // width of one queue entry: kind, four coords, span, twice rise, step,
  // vertical, active, colour
  function automatic int entry_bits(input int coord_bits);
    return 6 * coord_bits + 6 + COLOUR_BITS;
  endfunction

endpackage

// File: design/line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer
// turns two endpoints and a colour into a stream of line pixels
// ----------------------------------------------------------------------------
// usage
//   input words: kind_i low loads a line (endpoints and colour), kind_i high
//   is a step tick that asks for the next pixel. a load never gives a pixel;
//   a tick gives one pixel while a line is running and nothing otherwise.
//   loading while a line runs drops the old line
//   output words: one pixel with its colour, last_pixel_o marks the end
//   both channels move a word when valid is high and stall is low
// timing
//   a tick is written into the queue, then the back stage steps it into the
//   output register; one word in and one pixel out per cycle sustained while
//   neither channel stalls, each step a single add, subtract and compare pass
//   of the error register in the back stage; a two-word queue sits between
//   the front and back stages, so input stalls only once that queue is full
// reset
//   clears the queue, the running line and the output register; nothing is
//   active until the first load
// stall on the output
//   the pixel is held in the output register, the back stage pauses on a tick
//   in a line, and the queue fills to its two words before in_stall_o rises
// ----------------------------------------------------------------------------
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic signed [COORD_BITS-1:0]   start_x_i,
  input  logic signed [COORD_BITS-1:0]   start_y_i,
  input  logic signed [COORD_BITS-1:0]   end_x_i,
  input  logic signed [COORD_BITS-1:0]   end_y_i,
  input  logic [lr_pkg::COLOUR_BITS-1:0] line_colour_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [COORD_BITS-1:0]   pixel_x_o,
  output logic signed [COORD_BITS-1:0]   pixel_y_o,
  output logic [lr_pkg::COLOUR_BITS-1:0] pixel_colour_o,
  output logic                           last_pixel_o
);

  localparam int EntryBits = lr_pkg::entry_bits(COORD_BITS);

  // front to queue
  logic                 push, queue_full;
  logic [EntryBits-1:0] push_entry;
  // queue to back
  logic                 head_valid, pop;
  logic [EntryBits-1:0] head_entry;

  // ordering and classification of each word
  lr_front #(
    .COORD_BITS (COORD_BITS),
    .EntryBits  (EntryBits)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_colour_i (line_colour_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // decoupling queue
  lr_fifo #(
    .WIDTH (EntryBits)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_entry),
    .pop_i        (pop),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_data_o  (head_entry)
  );

  // stepping engine and output register
  lr_back #(
    .COORD_BITS (COORD_BITS),
    .EntryBits  (EntryBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_data_i    (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

// File: design/lr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_front
// input side: takes words, orders endpoints and classifies each line
// ----------------------------------------------------------------------------
module lr_front #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT,
  parameter int EntryBits  = lr_pkg::entry_bits(COORD_BITS)
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  logic [lr_pkg::COLOUR_BITS-1:0] line_colour_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output logic [EntryBits-1:0]          entry_o
);

  typedef struct packed {
    logic                            kind;
    logic signed [COORD_BITS-1:0]    first_x;
    logic signed [COORD_BITS-1:0]    first_y;
    logic signed [COORD_BITS-1:0]    stop_x;
    logic signed [COORD_BITS-1:0]    stop_y;
    logic [COORD_BITS-1:0]           span_x;
    logic [COORD_BITS:0]             twice_rise;
    logic signed [1:0]               y_step;
    logic                            vertical;
    logic                            active;
    logic [lr_pkg::COLOUR_BITS-1:0]  colour;
  } entry_t;

  logic signed [COORD_BITS:0] diff_x, diff_y, span, rise, rise_abs;
  logic                       start_first;
  entry_t                     entry;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    diff_x = $signed({end_x_i[COORD_BITS-1], end_x_i}) -
             $signed({start_x_i[COORD_BITS-1], start_x_i});
    diff_y = $signed({end_y_i[COORD_BITS-1], end_y_i}) -
             $signed({start_y_i[COORD_BITS-1], start_y_i});
    // smaller x first, then smaller y; a full tie keeps the end first
    start_first = (diff_x != '0) ? (diff_x > 0) : (diff_y > 0);
    span     = start_first ? diff_x : -diff_x;
    rise     = start_first ? diff_y : -diff_y;
    rise_abs = (rise < 0) ? -rise : rise;

    entry.kind       = kind_i;
    entry.first_x    = start_first ? start_x_i : end_x_i;
    entry.first_y    = start_first ? start_y_i : end_y_i;
    entry.stop_x     = start_first ? end_x_i : start_x_i;
    entry.stop_y     = start_first ? end_y_i : start_y_i;
    entry.span_x     = span[COORD_BITS-1:0];
    entry.twice_rise = {rise_abs[COORD_BITS-1:0], 1'b0};
    if (rise < 0) begin
      entry.y_step = lr_pkg::Y_STEP_DOWN;
    end else if (rise > 0) begin
      entry.y_step = lr_pkg::Y_STEP_UP;
    end else begin
      entry.y_step = lr_pkg::Y_STEP_NONE;
    end
    entry.vertical = (diff_x == '0);
    // a vertical line with equal ends has no pixels
    entry.active   = (diff_x != '0) || (diff_y != '0);
    entry.colour   = line_colour_i;
  end

  assign entry_o = entry;

endmodule

// File: design/lr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_fifo
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module lr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output logic [WIDTH-1:0] head_data_o
);

  localparam int DEPTH    = 2;
  localparam int PtrBits  = $clog2(DEPTH);
  localparam int CntBits  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o       = (count_q == CntBits'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/lr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_back
// stepping engine: walks the line one pixel per tick into an output register
// ----------------------------------------------------------------------------
module lr_back #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT,
  parameter int EntryBits  = lr_pkg::entry_bits(COORD_BITS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  logic [EntryBits-1:0]           head_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [COORD_BITS-1:0]   pixel_x_o,
  output logic signed [COORD_BITS-1:0]   pixel_y_o,
  output logic [lr_pkg::COLOUR_BITS-1:0] pixel_colour_o,
  output logic                           last_pixel_o
);

  typedef struct packed {
    logic                            kind;
    logic signed [COORD_BITS-1:0]    first_x;
    logic signed [COORD_BITS-1:0]    first_y;
    logic signed [COORD_BITS-1:0]    stop_x;
    logic signed [COORD_BITS-1:0]    stop_y;
    logic [COORD_BITS-1:0]           span_x;
    logic [COORD_BITS:0]             twice_rise;
    logic signed [1:0]               y_step;
    logic                            vertical;
    logic                            active;
    logic [lr_pkg::COLOUR_BITS-1:0]  colour;
  } entry_t;

  localparam int ErrBits = COORD_BITS + 4;

  entry_t head;

  // line state
  logic                           busy_q, busy_d;
  logic                           open_q, open_d;
  logic signed [COORD_BITS-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0]   stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic [COORD_BITS-1:0]          span_q, span_d;
  logic [COORD_BITS+1:0]          three_span_q, three_span_d;
  logic [COORD_BITS:0]            rise_q, rise_d;
  logic signed [ErrBits-1:0]      err_q, err_d;
  logic signed [1:0]              step_q, step_d;
  logic                           vert_q, vert_d;
  logic [lr_pkg::COLOUR_BITS-1:0] colour_q, colour_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0]   out_x_q, out_x_d, out_y_q, out_y_d;
  logic [lr_pkg::COLOUR_BITS-1:0] out_colour_q, out_colour_d;
  logic                           out_last_q, out_last_d;

  logic                           out_free, emit, last;
  logic signed [ErrBits-1:0]      err_add, err_sub, span_ext, two_span_ext, three_ext;
  logic signed [COORD_BITS:0]     x_next, y_next;
  logic                           pass_one, pass_two;

  assign head = entry_t'(head_data_i);

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_valid_i &&
                    ((head.kind == lr_pkg::KIND_LOAD) || !busy_q || out_free);
  assign emit     = pop_o && (head.kind == lr_pkg::KIND_TICK) && busy_q;

  always_comb begin
    span_ext     = $signed({{(ErrBits-COORD_BITS){1'b0}}, span_q});
    two_span_ext = $signed({{(ErrBits-COORD_BITS-1){1'b0}}, span_q, 1'b0});
    three_ext    = $signed({{(ErrBits-COORD_BITS-2){1'b0}}, three_span_q});
    err_add      = open_q ? err_q
                          : err_q + $signed({{(ErrBits-COORD_BITS-1){1'b0}}, rise_q});
    // first move once at span, a second pending move once at three spans
    pass_one     = (err_add >= span_ext);
    pass_two     = (err_add >= three_ext);
    err_sub      = err_add - two_span_ext;
    x_next       = $signed({cur_x_q[COORD_BITS-1], cur_x_q}) +
                   $signed({{COORD_BITS{1'b0}}, 1'b1});
    y_next       = $signed({cur_y_q[COORD_BITS-1], cur_y_q}) +
                   $signed({{COORD_BITS{1'b0}}, 1'b1});
  end

  always_comb begin
    busy_d       = busy_q;
    open_d       = open_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    stop_x_d     = stop_x_q;
    stop_y_d     = stop_y_q;
    span_d       = span_q;
    three_span_d = three_span_q;
    rise_d       = rise_q;
    err_d        = err_q;
    step_d       = step_q;
    vert_d       = vert_q;
    colour_d     = colour_q;
    out_valid_d  = out_free ? 1'b0 : out_valid_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_colour_d = out_colour_q;
    out_last_d   = out_last_q;
    last         = 1'b0;

    if (pop_o && (head.kind == lr_pkg::KIND_LOAD)) begin
      busy_d       = head.active;
      open_d       = 1'b0;
      cur_x_d      = head.first_x;
      cur_y_d      = head.first_y;
      stop_x_d     = head.stop_x;
      stop_y_d     = head.stop_y;
      span_d       = head.span_x;
      three_span_d = {2'b00, head.span_x} + {1'b0, head.span_x, 1'b0};
      rise_d       = head.twice_rise;
      err_d        = '0;
      step_d       = head.y_step;
      vert_d       = head.vertical;
      colour_d     = head.colour;
    end else if (emit) begin
      out_valid_d  = 1'b1;
      out_x_d      = cur_x_q;
      out_y_d      = cur_y_q;
      out_colour_d = colour_q;
      if (vert_q) begin
        last    = (y_next >= $signed({stop_y_q[COORD_BITS-1], stop_y_q}));
        cur_y_d = y_next[COORD_BITS-1:0];
      end else begin
        err_d = pass_one ? err_sub : err_add;
        if (pass_one) begin
          cur_y_d = cur_y_q + $signed({{(COORD_BITS-2){step_q[1]}}, step_q});
        end
        if (pass_two) begin
          open_d = 1'b1;
        end else begin
          open_d  = 1'b0;
          last    = (x_next >= $signed({stop_x_q[COORD_BITS-1], stop_x_q}));
          cur_x_d = x_next[COORD_BITS-1:0];
        end
      end
      out_last_d = last;
      busy_d     = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    open_q       <= open_d;
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    stop_x_q     <= stop_x_d;
    stop_y_q     <= stop_y_d;
    span_q       <= span_d;
    three_span_q <= three_span_d;
    rise_q       <= rise_d;
    err_q        <= err_d;
    step_q       <= step_d;
    vert_q       <= vert_d;
    colour_q     <= colour_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_colour_q <= out_colour_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign pixel_colour_o = out_colour_q;
  assign last_pixel_o   = out_last_q;

endmodule

// File: design/lr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_checker
// port-level checks on the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`include "line_rasterizer_assert.svh"

module lr_checker #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           kind_i,
  input logic signed [COORD_BITS-1:0]   start_x_i,
  input logic signed [COORD_BITS-1:0]   start_y_i,
  input logic signed [COORD_BITS-1:0]   end_x_i,
  input logic signed [COORD_BITS-1:0]   end_y_i,
  input logic [lr_pkg::COLOUR_BITS-1:0] line_colour_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [COORD_BITS-1:0]   pixel_x_o,
  input logic signed [COORD_BITS-1:0]   pixel_y_o,
  input logic [lr_pkg::COLOUR_BITS-1:0] pixel_colour_o,
  input logic                           last_pixel_o
);

  // a stalled pixel stays offered
  `LR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // and keeps its value
  `LR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(pixel_colour_o) && $stable(last_pixel_o))

  // the queue only fills up through an accepted word
  `LR_ASSERT_NOW(a_stall_cause, $rose(in_stall_o), $past(in_valid_i && !in_stall_o))

  // fresh out of reset: nothing offered, nothing stalled
  `LR_ASSERT_NOW(a_reset_clean, $past(!rst_ni), !out_valid_o && !in_stall_o)

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);

// File: tb/line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// self-checking bench for the line rasterizer: a clocked driver feeds load and
// tick words from a queue, a clocked monitor takes pixels, and a line model
// kept in step with accepted words predicts every pixel and its last flag
// ----------------------------------------------------------------------------
module line_rasterizer_tb;

  localparam int CB = lr_pkg::COORD_BITS_DEFAULT;
  localparam int CW = lr_pkg::COLOUR_BITS;
  localparam longint COORD_MIN = -(longint'(1) << (CB - 1));
  localparam longint COORD_MAX = (longint'(1) << (CB - 1)) - 1;
  localparam int TARGET_WORDS = 1550;
  localparam int TAIL_WORDS = 200;

  typedef struct {
    logic kind;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
    logic [CW-1:0] colour;
  } line_word_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [CW-1:0] colour;
    logic last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = lr_pkg::KIND_TICK;
  logic signed [CB-1:0] start_x_i = '0;
  logic signed [CB-1:0] start_y_i = '0;
  logic signed [CB-1:0] end_x_i = '0;
  logic signed [CB-1:0] end_y_i = '0;
  logic [CW-1:0] line_colour_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CB-1:0] pixel_x_o;
  logic signed [CB-1:0] pixel_y_o;
  logic [CW-1:0] pixel_colour_o;
  logic last_pixel_o;

  line_word_t line_words[$];      // words still to be driven
  pixel_t expected_pixels[$];     // pixels predicted but not yet seen
  line_word_t drive_word;
  int words_total = 0;
  int words_taken = 0;
  int fail_count = 0;

  // line model state
  bit run_busy = 1'b0;
  longint run_x = 0, run_y = 0, run_stop_x = 0, run_stop_y = 0;
  longint run_span = 0, run_rise2 = 0, run_err = 0;
  logic signed [1:0] run_step = lr_pkg::Y_STEP_NONE;
  bit run_vertical = 1'b0;
  bit run_column_open = 1'b0;
  logic [CW-1:0] run_colour = '0;

  always #5 clk_i = ~clk_i;

  line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_colour_i (line_colour_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_colour_o(pixel_colour_o),
    .last_pixel_o  (last_pixel_o)
  );

  // ---------------------------------------------------------------------------
  // line model
  // ---------------------------------------------------------------------------

  // stored coordinates wrap to the port width
  function automatic longint wrap_coord(input longint v);
    logic signed [CB-1:0] t;
    t = v[CB-1:0];
    return t;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // advance the model by one accepted word, queueing the pixel it gives
  task automatic rasterize_word(input line_word_t w);
    longint sx, sy, ex, ey, ax, ay, bx, by, rise;
    bit start_first;
    pixel_t px;
    if (w.kind == lr_pkg::KIND_LOAD) begin
      sx = w.sx;
      sy = w.sy;
      ex = w.ex;
      ey = w.ey;
      // smaller x first, then smaller y; a full tie puts the end point first
      if (sx != ex) start_first = (sx < ex);
      else start_first = (sy < ey);
      ax = start_first ? sx : ex;
      ay = start_first ? sy : ey;
      bx = start_first ? ex : sx;
      by = start_first ? ey : sy;
      rise = by - ay;
      run_x = ax;
      run_y = ay;
      run_stop_x = bx;
      run_stop_y = by;
      run_span = bx - ax;
      run_rise2 = 2 * (rise < 0 ? -rise : rise);
      run_step = rise < 0 ? lr_pkg::Y_STEP_DOWN
                          : (rise > 0 ? lr_pkg::Y_STEP_UP : lr_pkg::Y_STEP_NONE);
      run_err = 0;
      run_column_open = 1'b0;
      run_colour = w.colour;
      run_vertical = (ax == bx);
      // equal endpoints leave the model idle
      run_busy = run_vertical ? (ay < by) : 1'b1;
    end else if (run_busy) begin
      px.x = run_x[CB-1:0];
      px.y = run_y[CB-1:0];
      px.colour = run_colour;
      if (run_vertical) begin
        px.last = (run_y + 1 >= run_stop_y);
        run_y = wrap_coord(run_y + 1);
      end else begin
        // a column takes its rise once, then y catches up one step per tick
        if (!run_column_open) run_err += run_rise2;
        if (run_err >= run_span) begin
          run_y = wrap_coord(run_y + longint'(run_step));
          run_err -= 2 * run_span;
        end
        if (run_err >= run_span) begin
          run_column_open = 1'b1;
          px.last = 1'b0;
        end else begin
          run_column_open = 1'b0;
          px.last = (run_x + 1 >= run_stop_x);
          run_x = wrap_coord(run_x + 1);
        end
      end
      if (px.last) run_busy = 1'b0;
      expected_pixels = {expected_pixels, px};
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic queue_load(input longint sx, input longint sy, input longint ex,
                            input longint ey, input logic [CW-1:0] colour);
    line_word_t w;
    w.kind = lr_pkg::KIND_LOAD;
    w.sx = sx[CB-1:0];
    w.sy = sy[CB-1:0];
    w.ex = ex[CB-1:0];
    w.ey = ey[CB-1:0];
    w.colour = colour;
    line_words = {line_words, w};
  endtask

  // ticks carry random rubbish in the unused fields
  task automatic queue_ticks(input int n);
    line_word_t w;
    repeat (n) begin
      w.kind = lr_pkg::KIND_TICK;
      w.sx = CB'($urandom);
      w.sy = CB'($urandom);
      w.ex = CB'($urandom);
      w.ey = CB'($urandom);
      w.colour = CW'($urandom);
      line_words = {line_words, w};
    end
  endtask

  function automatic longint any_coord();
    return longint'($urandom_range(0, 65535)) + COORD_MIN;
  endfunction

  // end point a short offset away, mirrored when it would leave the range
  function automatic longint offset_coord(input longint base, input longint d);
    if (base + d > COORD_MAX || base + d < COORD_MIN) return base - d;
    return base + d;
  endfunction

  task automatic build_directed();
    queue_ticks(1);                                                  // tick while idle
    queue_load(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 24'hFFFFFF);
    queue_ticks(3);
    // load while busy, endpoints given in reverse order
    queue_load(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'h000000);
    queue_ticks(2);
    // vertical line given top down, one spare tick after its end
    queue_load(5, 7, 5, 3, 24'h123456);
    queue_ticks(5);
    // equal endpoints: nothing to draw
    queue_load(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 24'hA5A5A5);
    queue_ticks(1);
    queue_load(13, 2, 10, 2, 24'h5A5A5A);                            // flat line
    queue_ticks(3);
    queue_load(0, 0, 1, 3, 24'h00FF00);                              // steep line
    queue_ticks(3);
  endtask

  task automatic build_random();
    int counted, pick, ticks;
    longint bx, by, dx, dy;
    counted = 0;
    while (counted < TARGET_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        // well-formed line with random content, usually drawn to its end
        bx = any_coord();
        by = any_coord();
        dx = (pick < 70) ? longint'($urandom_range(0, 24)) - 12 : 0;
        dy = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 80)) - 40
                                          : longint'($urandom_range(0, 24)) - 12;
        queue_load(bx, by, offset_coord(bx, dx), offset_coord(by, dy), CW'($urandom));
        ticks = int'((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy)) + $urandom_range(0, 2);
        // now and then cut the line short with the next load
        if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, ticks);
        queue_ticks(ticks);
        counted += 1 + ticks;
      end else if (pick < 93) begin
        // full range endpoints, normally dropped by the next load
        queue_load(any_coord(), any_coord(), any_coord(), any_coord(), CW'($urandom));
        ticks = $urandom_range(0, 6);
        queue_ticks(ticks);
        counted += 1 + ticks;
      end else begin
        queue_ticks($urandom_range(1, 5));
      end
    end
  endtask

  // pause rate: 0 none, 1 light, 2 heavy
  function automatic bit start_pause(input int rate);
    if (rate == 1) return $urandom_range(0, 15) == 0;
    if (rate == 2) return $urandom_range(0, 3) == 0;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued words, models each one as it is taken
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  int in_rate = 0;
  int in_cycle = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= lr_pkg::KIND_TICK;
      start_x_i <= '0;
      start_y_i <= '0;
      end_x_i <= '0;
      end_y_i <= '0;
      line_colour_i <= '0;
    end else begin
      in_cycle++;
      if (in_cycle % 256 == 0) in_rate = $urandom_range(0, 2);
      if (in_valid_i && !in_stall_o) begin
        rasterize_word(drive_word);
        words_taken++;
      end
      // a stalled word stays as it is
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (line_words.size() > TAIL_WORDS && start_pause(in_rate)) begin
          in_gap = $urandom_range(1, 14) - 1;
          in_valid_i <= 1'b0;
        end else if (line_words.size() > 0) begin
          drive_word = line_words.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= drive_word.kind;
          start_x_i <= drive_word.sx;
          start_y_i <= drive_word.sy;
          end_x_i <= drive_word.ex;
          end_y_i <= drive_word.ey;
          line_colour_i <= drive_word.colour;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes pixels under random stall, checks against the model
  // ---------------------------------------------------------------------------
  int out_gap = 0;
  int out_rate = 0;
  int out_cycle = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_cycle++;
      if (out_cycle % 256 == 128) out_rate = $urandom_range(0, 2);
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel x=%0d y=%0d colour=%06h last=%0b",
                                 pixel_x_o, pixel_y_o, pixel_colour_o, last_pixel_o));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x_o !== want.x || pixel_y_o !== want.y ||
              pixel_colour_o !== want.colour || last_pixel_o !== want.last) begin
            note_failure($sformatf(
              "expected x=%0d y=%0d colour=%06h last=%0b, got x=%0d y=%0d colour=%06h last=%0b",
              want.x, want.y, want.colour, want.last,
              pixel_x_o, pixel_y_o, pixel_colour_o, last_pixel_o));
          end
        end
      end
      // stall bursts stop for the tail of the run
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (line_words.size() > TAIL_WORDS && start_pause(out_rate)) begin
        out_gap = $urandom_range(1, 14) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    build_directed();
    build_random();
    words_total = line_words.size();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (words_taken < words_total) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    // let a late word surface before deciding
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS line_rasterizer");
    end else begin
      $display("FAIL line_rasterizer");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL line_rasterizer");
    $finish;
  end

endmodule
